>>> hw/rtl/fccw_pkg.sv
// fccw_pkg: shared types and constants for the FAT12 cluster chain walker.
// No dependencies; fccw_front, fccw_back and the top level import it.
package fccw_pkg;

  // Input command codes
  localparam logic [1:0] CMD_LOAD    = 2'd0;
  localparam logic [1:0] CMD_OPEN    = 2'd1;
  localparam logic [1:0] CMD_ADVANCE = 2'd2;

  // Configuration register indexes
  localparam int                     CFG_INDEX_W    = 2;
  localparam logic [CFG_INDEX_W-1:0] CFG_SPC        = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_DATA_START = 2'd1;

  localparam logic [11:0] END_MARK      = 12'hFF8;
  localparam logic [31:0] FIRST_CLUSTER = 32'd2;
  localparam logic [7:0]  SPC_MAX       = 8'd128;
  localparam logic [7:0]  SPC_MIN       = 8'd1;

  // Depth of the queue between front and back, and of the result queue
  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [12:0] table_index;
    logic [7:0]  table_byte;
    logic [11:0] start_cluster;
  } in_word_t;

  typedef struct packed {
    logic [31:0] sector_lba;
    logic        chain_end;
    logic [11:0] cluster_now;
  } out_word_t;

  typedef enum logic [1:0] {
    OP_LOAD,
    OP_OPEN,
    OP_ADVANCE
  } op_kind_t;

  // Classified word handed from front to back
  typedef struct packed {
    op_kind_t    kind;
    logic [12:0] addr;
    logic [7:0]  data;
    logic [11:0] cluster;
  } op_t;

endpackage

>>> hw/rtl/fccw_ram.sv
// fccw_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module fccw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> hw/rtl/fccw_fifo.sv
// fccw_fifo: small register queue with full/empty flags.
// No dependencies.
module fccw_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

>>> hw/rtl/fccw_front.sv
// fccw_front: accepts input words, classifies them and queues the ones with work.
// Depends on fccw_pkg and fccw_fifo.
module fccw_front import fccw_pkg::*; #(
  parameter int TABLE_BYTES = 8192
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_push,
  input  in_word_t in_data,
  output logic     in_full,
  input  logic     op_pop,
  output op_t      op,
  output logic     op_empty
);

  logic take;
  logic keep;
  op_t  op_in;

  assign take = in_push && !in_full;

  // Loads past the table and the unused command are dropped here.
  always_comb begin
    op_in.addr    = in_data.table_index;
    op_in.data    = in_data.table_byte;
    op_in.cluster = in_data.start_cluster;
    op_in.kind    = OP_LOAD;
    keep          = 1'b0;
    unique case (in_data.cmd)
      CMD_LOAD: begin
        op_in.kind = OP_LOAD;
        keep       = int'(in_data.table_index) < TABLE_BYTES;
      end
      CMD_OPEN: begin
        op_in.kind = OP_OPEN;
        keep       = 1'b1;
      end
      CMD_ADVANCE: begin
        op_in.kind = OP_ADVANCE;
        keep       = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  fccw_fifo #(
    .WIDTH ($bits(op_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_op_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (take && keep),
    .wdata (op_in),
    .full  (in_full),
    .pop   (op_pop),
    .rdata (op),
    .empty (op_empty)
  );

endmodule

>>> hw/rtl/fccw_back.sv
// fccw_back: walks the chain: FAT banks, cluster/sector state, LBA pipeline, result queue.
// Depends on fccw_pkg, fccw_ram and fccw_fifo.
module fccw_back import fccw_pkg::*; #(
  parameter int TABLE_BYTES = 8192
) (
  input  logic        clk,
  input  logic        rst_n,
  input  op_t         op,
  input  logic        op_empty,
  output logic        op_pop,
  input  logic [7:0]  spc,
  input  logic [31:0] data_start,
  input  logic        out_pop,
  output out_word_t   out_data,
  output logic        out_empty
);

  // FAT bytes split by address parity so both bytes of an entry read at once
  localparam int          BANK_DEPTH  = (TABLE_BYTES + 1) / 2;
  localparam int          BANK_AW     = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
  localparam logic [13:0] TABLE_LIMIT = 14'(TABLE_BYTES);

  logic [11:0] cluster_r, cluster_nxt;
  logic [6:0]  sector_r, sector_nxt;
  logic        fetch_r, fetch_nxt;
  logic        fodd_r, iodd_r, lo_ok_r, hi_ok_r;

  logic        s_valid_r, s_valid_nxt;
  logic [11:0] s_cluster_r;
  logic [6:0]  s_sector_r;

  logic        p_valid_r;
  logic [31:0] p_prod_r, p_base_r;
  logic        p_end_r;
  logic [11:0] p_cluster_r;

  logic [7:0]  eff_spc;
  logic        cur_end, wrap;
  logic [7:0]  sector_inc;
  logic [13:0] fat_idx, fat_idx_hi;
  logic        we_even, we_odd, fat_re;
  logic [7:0]  even_q, odd_q, lo_byte, hi_byte;
  logic [15:0] fat_word;
  logic [11:0] next_cluster;
  logic        snap;
  logic        p_adv, s_adv;
  logic        out_full;
  logic [31:0] rel_cluster;
  logic [39:0] mul_full;
  out_word_t   res;

  // 0 acts as 1, above 128 acts as 128
  always_comb begin
    if (spc < SPC_MIN) begin
      eff_spc = SPC_MIN;
    end else if (spc > SPC_MAX) begin
      eff_spc = SPC_MAX;
    end else begin
      eff_spc = spc;
    end
  end

  assign cur_end    = cluster_r >= END_MARK;
  assign sector_inc = {1'b0, sector_r} + 8'd1;
  assign wrap       = sector_inc >= eff_spc;
  assign fat_idx    = {2'b00, cluster_r} + {3'b000, cluster_r[11:1]};
  assign fat_idx_hi = fat_idx + 14'd1;

  // FAT entry assembly from the two banks
  always_comb begin
    lo_byte      = iodd_r ? odd_q : even_q;
    hi_byte      = iodd_r ? even_q : odd_q;
    fat_word     = {hi_ok_r ? hi_byte : 8'h00, lo_ok_r ? lo_byte : 8'h00};
    next_cluster = fodd_r ? fat_word[15:4] : fat_word[11:0];
  end

  assign p_adv = !p_valid_r || !out_full;
  assign s_adv = !s_valid_r || p_adv;

  // Execute stage
  always_comb begin
    op_pop      = 1'b0;
    snap        = 1'b0;
    cluster_nxt = cluster_r;
    sector_nxt  = sector_r;
    fetch_nxt   = fetch_r;
    we_even     = 1'b0;
    we_odd      = 1'b0;
    fat_re      = 1'b0;
    if (fetch_r) begin
      if (s_adv) begin
        cluster_nxt = next_cluster;
        sector_nxt  = '0;
        fetch_nxt   = 1'b0;
        snap        = 1'b1;
      end
    end else if (!op_empty) begin
      unique case (op.kind)
        OP_LOAD: begin
          op_pop  = 1'b1;
          we_even = !op.addr[0];
          we_odd  = op.addr[0];
        end
        OP_OPEN: begin
          if (s_adv) begin
            op_pop      = 1'b1;
            cluster_nxt = op.cluster;
            sector_nxt  = '0;
            snap        = 1'b1;
          end
        end
        OP_ADVANCE: begin
          if (cur_end) begin
            if (s_adv) begin
              op_pop = 1'b1;
              snap   = 1'b1;
            end
          end else if (wrap) begin
            op_pop    = 1'b1;
            fat_re    = 1'b1;
            fetch_nxt = 1'b1;
          end else if (s_adv) begin
            op_pop     = 1'b1;
            sector_nxt = sector_inc[6:0];
            snap       = 1'b1;
          end
        end
        default: begin
          op_pop = 1'b0;
        end
      endcase
    end
  end

  assign s_valid_nxt = s_adv ? snap : s_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cluster_r <= '0;
      sector_r  <= '0;
      fetch_r   <= 1'b0;
      s_valid_r <= 1'b0;
      p_valid_r <= 1'b0;
    end else begin
      cluster_r <= cluster_nxt;
      sector_r  <= sector_nxt;
      fetch_r   <= fetch_nxt;
      s_valid_r <= s_valid_nxt;
      if (p_adv) begin
        p_valid_r <= s_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fat_re) begin
      fodd_r  <= cluster_r[0];
      iodd_r  <= fat_idx[0];
      lo_ok_r <= fat_idx < TABLE_LIMIT;
      hi_ok_r <= fat_idx_hi < TABLE_LIMIT;
    end
    if (s_adv) begin
      s_cluster_r <= cluster_nxt;
      s_sector_r  <= sector_nxt;
    end
  end

  // Multiply stage: (cluster - 2) * spc wraps modulo 2^32
  assign rel_cluster = {20'd0, s_cluster_r} - FIRST_CLUSTER;
  assign mul_full    = rel_cluster * eff_spc;

  always_ff @(posedge clk) begin
    if (p_adv) begin
      p_prod_r    <= mul_full[31:0];
      p_base_r    <= data_start + {25'd0, s_sector_r};
      p_end_r     <= s_cluster_r >= END_MARK;
      p_cluster_r <= s_cluster_r;
    end
  end

  always_comb begin
    res.sector_lba  = p_end_r ? '0 : p_prod_r + p_base_r;
    res.chain_end   = p_end_r;
    res.cluster_now = p_cluster_r;
  end

  fccw_ram #(
    .WIDTH (8),
    .DEPTH (BANK_DEPTH)
  ) u_even_bank (
    .clk   (clk),
    .we    (we_even),
    .waddr (op.addr[BANK_AW:1]),
    .wdata (op.data),
    .re    (fat_re),
    .raddr (fat_idx_hi[BANK_AW:1]),
    .rdata (even_q)
  );

  fccw_ram #(
    .WIDTH (8),
    .DEPTH (BANK_DEPTH)
  ) u_odd_bank (
    .clk   (clk),
    .we    (we_odd),
    .waddr (op.addr[BANK_AW:1]),
    .wdata (op.data),
    .re    (fat_re),
    .raddr (fat_idx[BANK_AW:1]),
    .rdata (odd_q)
  );

  fccw_fifo #(
    .WIDTH ($bits(out_word_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_out_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (p_valid_r),
    .wdata (res),
    .full  (out_full),
    .pop   (out_pop),
    .rdata (out_data),
    .empty (out_empty)
  );

endmodule

>>> hw/rtl/fat12_cluster_chain_sector_walker_unit.sv
// fat12_cluster_chain_sector_walker_unit: top level of the FAT12 chain walker.
// Depends on fccw_pkg, fccw_front and fccw_back.
//
// Walks a FAT12 cluster chain one sector per word. Software first loads the FAT
// bytes (cmd load, no result), then an open word starts a chain and each advance
// word steps one sector, following the packed 12-bit FAT entry at the end of a
// cluster. Each open or advance gives one result word: the sector LBA, the
// cluster and an end-of-chain flag (LBA reads 0 once the cluster is 0xFF8 or
// above). Reading a FAT byte that was never loaded gives an undefined cluster.
// Rate: one word per cycle while the result queue has room; an advance that
// leaves a cluster also holds the next word for the registered FAT bank read.
// A result passes the input queue, the execute and multiply stages and the
// result queue before it shows on the result ports. Both sides are queues, so
// input keeps flowing while a result waits for pop. cfg_ready is always high;
// write the registers only while no word is in flight.
module fat12_cluster_chain_sector_walker_unit import fccw_pkg::*; #(
  parameter int TABLE_BYTES = 8192
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // input queue side
  input  logic                   in_push,
  input  in_word_t               in_data,
  output logic                   in_full,
  // result queue side
  output logic                   out_empty,
  input  logic                   out_pop,
  output out_word_t              out_data,
  // configuration writes
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [31:0]            cfg_data
);

  logic [7:0]  spc_r, spc_nxt;
  logic [31:0] data_start_r, data_start_nxt;
  logic        cfg_write;

  op_t  op;
  logic op_empty;
  logic op_pop;

  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;

  // Unknown indexes are dropped
  always_comb begin
    spc_nxt        = spc_r;
    data_start_nxt = data_start_r;
    if (cfg_write) begin
      unique case (cfg_index)
        CFG_SPC:        spc_nxt        = cfg_data[7:0];
        CFG_DATA_START: data_start_nxt = cfg_data;
        default:        spc_nxt        = spc_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spc_r        <= SPC_MIN;
      data_start_r <= '0;
    end else begin
      spc_r        <= spc_nxt;
      data_start_r <= data_start_nxt;
    end
  end

  // Front: takes words, drops the ones without work
  fccw_front #(
    .TABLE_BYTES (TABLE_BYTES)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_data  (in_data),
    .in_full  (in_full),
    .op_pop   (op_pop),
    .op       (op),
    .op_empty (op_empty)
  );

  // Back: FAT banks, chain state, LBA math, result queue
  fccw_back #(
    .TABLE_BYTES (TABLE_BYTES)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .op         (op),
    .op_empty   (op_empty),
    .op_pop     (op_pop),
    .spc        (spc_r),
    .data_start (data_start_r),
    .out_pop    (out_pop),
    .out_data   (out_data),
    .out_empty  (out_empty)
  );

  // An end-of-chain result carries LBA zero
  a_end_lba_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_data.chain_end) |-> (out_data.sector_lba == '0))
    else $error("end-of-chain word with nonzero LBA");

  // The end flag follows the reported cluster
  a_end_matches_cluster: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (out_data.chain_end == (out_data.cluster_now >= END_MARK)))
    else $error("end flag disagrees with cluster");

  // Reset leaves both queues empty
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (out_empty && !in_full))
    else $error("queues not empty after reset");

endmodule

>>> dv/fat12_cluster_chain_sector_walker_unit_test.sv
// Self-checking bench for fat12_cluster_chain_sector_walker_unit: directed script, then
// random FAT chains walked under several cluster sizes and data-area bases.
// Depends on fccw_pkg and the walker RTL only.
module fat12_cluster_chain_sector_walker_unit_test;
  import fccw_pkg::*;

  localparam int          TABLE_BYTES   = 8192;
  localparam int          CYCLE_LIMIT   = 200000;
  localparam int          SETTLE_CYCLES = 12;   // wait after the last result, for loads in flight
  localparam int          LONG_HOLD     = 80;   // sink stall, well past queue depth
  localparam int          MAX_REPORTS   = 10;
  localparam logic [1:0]  CMD_NONE      = 2'd3; // unused code, block ignores it
  localparam logic [11:0] RESERVED_TOP  = 12'hFF7;

  // One line of the directed script: a register write or a word, with the
  // result typed in where it is obvious.
  typedef struct packed {
    bit                     is_reg;
    logic [CFG_INDEX_W-1:0] sel;
    logic [31:0]            val;
    in_word_t               w;
    bit                     typed;
    out_word_t              want;
  } script_row_t;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_push;
  in_word_t               in_data;
  logic                   in_full;
  logic                   out_empty;
  logic                   out_pop;
  out_word_t              out_data;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [31:0]            cfg_data;

  fat12_cluster_chain_sector_walker_unit #(
    .TABLE_BYTES(TABLE_BYTES)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_data  (in_data),
    .in_full  (in_full),
    .out_empty(out_empty),
    .out_pop  (out_pop),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Walker image: FAT bytes (with a loaded flag per byte), position in the
  // chain and the two registers. Updated at each accepted word or write.
  // ---------------------------------------------------------------------------
  logic [7:0]  fat_img  [0:TABLE_BYTES-1];
  bit          fat_seen [0:TABLE_BYTES-1];
  logic [11:0] walk_cluster;
  logic [6:0]  walk_sector;
  logic [7:0]  spc_reg;
  logic [31:0] lba_base;

  out_word_t   sectors_due[$];   // predicted result words, oldest first
  int          mismatches;
  bit          sender_quiet;
  bit          sink_quiet;

  // Out-of-range cluster sizes clamp to 1..128.
  function automatic logic [7:0] spc_eff();
    if (spc_reg == 8'd0) return SPC_MIN;
    if (spc_reg > SPC_MAX) return SPC_MAX;
    return spc_reg;
  endfunction

  // Byte offset of a packed 12-bit entry: cluster * 3 / 2. Tops out at 6142,
  // so a FAT read past the table cannot happen at this table size.
  function automatic logic [12:0] entry_addr(input logic [11:0] c);
    logic [13:0] x3;
    x3 = {2'b00, c} * 14'd3;
    return x3[13:1];
  endfunction

  function automatic logic [11:0] fat_next(input logic [11:0] c);
    logic [12:0] at;
    logic [15:0] pair;
    at   = entry_addr(c);
    pair = {fat_img[at + 13'd1], fat_img[at]};
    return c[0] ? pair[15:4] : pair[11:0];
  endfunction

  // True when the next advance leaves the cluster and the entry it would read
  // has a byte that was never loaded.
  function automatic bit needs_unloaded_read();
    logic [12:0] at;
    at = entry_addr(walk_cluster);
    if (walk_cluster >= END_MARK) return 1'b0;
    if (8'(walk_sector) + 8'd1 < spc_eff()) return 1'b0;
    return !(fat_seen[at] && fat_seen[at + 13'd1]);
  endfunction

  function automatic out_word_t sector_report();
    out_word_t   r;
    logic [31:0] off;
    r.cluster_now = walk_cluster;
    if (walk_cluster >= END_MARK) begin
      r.sector_lba = '0;
      r.chain_end  = 1'b1;
    end else begin
      // 32-bit wrap is intended: clusters 0 and 1 land below the data area
      off          = ({20'd0, walk_cluster} - FIRST_CLUSTER) * {24'd0, spc_eff()};
      r.sector_lba = lba_base + off + {25'd0, walk_sector};
      r.chain_end  = 1'b0;
    end
    return r;
  endfunction

  // Applies one accepted word; returns 1 with the result when it makes one.
  function automatic bit chain_step(input in_word_t w, output out_word_t r);
    r = '0;
    case (w.cmd)
      CMD_LOAD: begin
        fat_img[w.table_index]  = w.table_byte;
        fat_seen[w.table_index] = 1'b1;
        return 1'b0;
      end
      CMD_OPEN: begin
        walk_cluster = w.start_cluster;
        walk_sector  = '0;
      end
      CMD_ADVANCE: begin
        // past the end marker the position is frozen
        if (walk_cluster < END_MARK) begin
          if (8'(walk_sector) + 8'd1 >= spc_eff()) begin
            walk_sector  = '0;
            walk_cluster = fat_next(walk_cluster);
          end else begin
            walk_sector = walk_sector + 7'd1;
          end
        end
      end
      default: return 1'b0;
    endcase
    r = sector_report();
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Random content
  // ---------------------------------------------------------------------------
  function automatic in_word_t rand_word(input logic [1:0] cmd);
    in_word_t w;
    w.cmd           = cmd;
    w.table_index   = 13'($urandom_range(0, TABLE_BYTES - 1));
    w.table_byte    = 8'($urandom_range(0, 255));
    w.start_cluster = 12'($urandom_range(0, 4095));
    return w;
  endfunction

  function automatic logic [11:0] pick_end();
    return END_MARK + 12'($urandom_range(0, 7));
  endfunction

  function automatic logic [11:0] pick_reserved();
    case ($urandom_range(0, 2))
      0:       return 12'd0;
      1:       return 12'd1;
      default: return RESERVED_TOP;
    endcase
  endfunction

  // Next-cluster values: mostly a small pool so chains revisit and loop,
  // some end markers, reserved clusters and anything at all.
  function automatic logic [11:0] pick_link();
    case ($urandom_range(0, 9))
      0, 1:    return pick_end();
      2:       return pick_reserved();
      3:       return 12'($urandom_range(0, 4095));
      default: return 12'($urandom_range(2, 40));
    endcase
  endfunction

  function automatic logic [11:0] pick_open();
    case ($urandom_range(0, 7))
      0, 1:    return 12'($urandom_range(0, 4095));
      2:       return $urandom_range(0, 1) ? pick_end() : pick_reserved();
      default: return 12'($urandom_range(2, 40));
    endcase
  endfunction

  // Per-word random wait, with runs where a side never waits.
  function automatic int draw_gap(inout bit quiet);
    if ($urandom_range(0, 39) == 0) quiet = ~quiet;
    return quiet ? 0 : $urandom_range(0, 5);
  endfunction

  function automatic void flag_fault(input string what);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("%0t: %s", $realtime, what);
  endfunction

  // ---------------------------------------------------------------------------
  // Input side. Everything moves at the falling edge; acceptance is seen at
  // the rising edge, where the image is stepped and the result queued.
  // ---------------------------------------------------------------------------
  task automatic send_word(input in_word_t w, input bit typed, input out_word_t want);
    int        gap;
    out_word_t r;
    gap = draw_gap(sender_quiet);
    if (gap > 0) begin
      @(negedge clk);
      in_push <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_push <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (in_full);
    if (chain_step(w, r)) sectors_due.push_back(typed ? want : r);
  endtask

  task automatic send_load(input logic [12:0] at, input logic [7:0] b);
    in_word_t w;
    w             = rand_word(CMD_LOAD);
    w.table_index = at;
    w.table_byte  = b;
    send_word(w, 1'b0, '0);
  endtask

  // Rewrites one packed entry with two byte loads, keeping the nibble that
  // belongs to the neighbouring cluster.
  task automatic set_fat_entry(input logic [11:0] c, input logic [11:0] nxt);
    logic [12:0] at;
    logic [7:0]  lo;
    logic [7:0]  hi;
    at = entry_addr(c);
    lo = fat_img[at];
    hi = fat_img[at + 13'd1];
    if (c[0]) begin
      lo = {nxt[3:0], lo[3:0]};
      hi = nxt[11:4];
    end else begin
      lo = nxt[7:0];
      hi = {hi[7:4], nxt[11:8]};
    end
    send_load(at, lo);
    send_load(at + 13'd1, hi);
  endtask

  // An advance that would read a never-loaded entry gets that entry first.
  task automatic send_advance();
    if (needs_unloaded_read()) set_fat_entry(walk_cluster, pick_link());
    send_word(rand_word(CMD_ADVANCE), 1'b0, '0);
  endtask

  // Stop offering, wait for every queued result, then let loads in flight
  // finish before anything touches the registers.
  task automatic settle();
    @(negedge clk);
    in_push <= 1'b0;
    wait (sectors_due.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] sel, input logic [31:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= sel;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (sel == CFG_SPC) spc_reg = val[7:0];
    else if (sel == CFG_DATA_START) lba_base = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Random phase: one register setting, an open to start, then mostly
  // advances with opens, entry rewrites, stray loads and unused codes mixed in.
  // Large clusters get few opens so walks still cross into the next cluster.
  // ---------------------------------------------------------------------------
  task automatic run_phase(input logic [7:0] spc, input logic [31:0] base, input int words);
    int       sent;
    int       roll;
    int       open_pct;
    in_word_t w;
    settle();
    write_reg(CFG_SPC, {24'd0, spc});
    write_reg(CFG_DATA_START, base);
    open_pct = (spc_eff() > 8'd8) ? 1 : 10;
    w = rand_word(CMD_OPEN);
    w.start_cluster = 12'($urandom_range(2, 40));
    send_word(w, 1'b0, '0);
    sent = 1;
    while (sent < words) begin
      roll = $urandom_range(0, 99);
      if (roll < 4) begin
        send_word(rand_word(CMD_NONE), 1'b0, '0);   // ignored, not counted
      end else begin
        sent++;
        if (roll < 12) begin
          send_word(rand_word(CMD_LOAD), 1'b0, '0);
        end else if (roll < 16) begin
          set_fat_entry(12'($urandom_range(2, 40)), pick_link());
        end else if (roll < 16 + open_pct) begin
          w = rand_word(CMD_OPEN);
          w.start_cluster = pick_open();
          send_word(w, 1'b0, '0);
        end else begin
          send_advance();
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Directed script builders
  // ---------------------------------------------------------------------------
  function automatic script_row_t drive_row(input logic [1:0] cmd, input logic [12:0] at,
                                            input logic [7:0] b, input logic [11:0] cl);
    script_row_t r;
    r                 = '0;
    r.w.cmd           = cmd;
    r.w.table_index   = at;
    r.w.table_byte    = b;
    r.w.start_cluster = cl;
    return r;
  endfunction

  function automatic script_row_t check_row(input logic [1:0] cmd, input logic [11:0] cl,
                                            input logic [31:0] lba, input bit last,
                                            input logic [11:0] now);
    script_row_t r;
    r                    = drive_row(cmd, '0, '0, cl);
    r.typed              = 1'b1;
    r.want.sector_lba    = lba;
    r.want.chain_end     = last;
    r.want.cluster_now   = now;
    return r;
  endfunction

  function automatic script_row_t reg_row(input logic [CFG_INDEX_W-1:0] sel,
                                          input logic [31:0] val);
    script_row_t r;
    r        = '0;
    r.is_reg = 1'b1;
    r.sel    = sel;
    r.val    = val;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: pops at its own pace and checks each word against the
  // oldest prediction. Two long holds fill the block and stall its input.
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int        gap;
    int        taken;
    out_word_t got;
    out_word_t want;
    out_pop    = 1'b0;
    sink_quiet = 1'b0;
    taken      = 0;
    wait (rst_n === 1'b1);
    forever begin
      gap = (taken == 60 || taken == 300) ? LONG_HOLD : draw_gap(sink_quiet);
      if (gap > 0) begin
        @(negedge clk);
        out_pop <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      @(negedge clk);
      out_pop <= 1'b1;
      do @(posedge clk); while (out_empty);
      got = out_data;
      taken++;
      if (sectors_due.size() == 0) begin
        flag_fault($sformatf("unexpected word: lba %h end %b cluster %h",
                             got.sector_lba, got.chain_end, got.cluster_now));
      end else begin
        want = sectors_due.pop_front();
        if (got.sector_lba !== want.sector_lba || got.chain_end !== want.chain_end ||
            got.cluster_now !== want.cluster_now)
          flag_fault($sformatf("exp lba %h end %b cluster %h, got lba %h end %b cluster %h",
                               want.sector_lba, want.chain_end, want.cluster_now,
                               got.sector_lba, got.chain_end, got.cluster_now));
      end
    end
  end

  initial begin : watchdog
    int cycles_run;
    cycles_run = 0;
    while (cycles_run < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles_run++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    script_row_t script[$];
    rst_n        = 1'b0;
    in_push      = 1'b0;
    in_data      = '0;
    cfg_valid    = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    mismatches   = 0;
    sender_quiet = 1'b0;
    walk_cluster = '0;
    walk_sector  = '0;
    spc_reg      = SPC_MIN;
    lba_base     = '0;
    foreach (fat_img[i]) begin
      fat_img[i]  = '0;
      fat_seen[i] = 1'b0;
    end

    // Reset registers: 1 sector per cluster, data area at LBA 0, so an open
    // of cluster c reads c - 2 modulo 2^32.
    script.push_back(check_row(CMD_OPEN, 12'd2, 32'd0, 1'b0, 12'd2));
    script.push_back(check_row(CMD_OPEN, 12'hFFF, 32'd0, 1'b1, 12'hFFF));
    script.push_back(check_row(CMD_ADVANCE, 12'd0, 32'd0, 1'b1, 12'hFFF)); // stuck at end
    script.push_back(check_row(CMD_OPEN, END_MARK, 32'd0, 1'b1, END_MARK));
    script.push_back(check_row(CMD_OPEN, RESERVED_TOP, 32'hFF5, 1'b0, RESERVED_TOP));
    script.push_back(check_row(CMD_OPEN, 12'd0, 32'hFFFF_FFFE, 1'b0, 12'd0));
    script.push_back(check_row(CMD_OPEN, 12'd1, 32'hFFFF_FFFF, 1'b0, 12'd1));
    script.push_back(drive_row(CMD_NONE, 13'h1FFF, 8'hFF, 12'hFFF));
    script.push_back(drive_row(CMD_LOAD, 13'h1FFF, 8'hFF, 12'd0));  // last table byte
    // chain 2 -> 3 -> end: entry 2 at bytes 3/4 low, entry 3 at bytes 4 high/5
    script.push_back(drive_row(CMD_LOAD, 13'd3, 8'h03, 12'd0));
    script.push_back(drive_row(CMD_LOAD, 13'd4, 8'hF0, 12'd0));
    script.push_back(drive_row(CMD_LOAD, 13'd5, 8'hFF, 12'd0));
    script.push_back(check_row(CMD_OPEN, 12'd2, 32'd0, 1'b0, 12'd2));
    script.push_back(check_row(CMD_ADVANCE, 12'd0, 32'd1, 1'b0, 12'd3));
    script.push_back(check_row(CMD_ADVANCE, 12'd0, 32'd0, 1'b1, 12'hFFF));
    // reserved cluster 0 links into cluster 2
    script.push_back(drive_row(CMD_LOAD, 13'd0, 8'h02, 12'd0));
    script.push_back(drive_row(CMD_LOAD, 13'd1, 8'h00, 12'd0));
    script.push_back(check_row(CMD_OPEN, 12'd0, 32'hFFFF_FFFE, 1'b0, 12'd0));
    script.push_back(check_row(CMD_ADVANCE, 12'd0, 32'd0, 1'b0, 12'd2));
    // cluster size 0 acts as 1, above 128 acts as 128
    script.push_back(reg_row(CFG_SPC, 32'd0));
    script.push_back(check_row(CMD_OPEN, 12'd3, 32'd1, 1'b0, 12'd3));
    script.push_back(reg_row(CFG_SPC, 32'd255));
    script.push_back(check_row(CMD_OPEN, 12'd3, 32'd128, 1'b0, 12'd3));
    script.push_back(drive_row(CMD_ADVANCE, 13'd0, 8'd0, 12'd0));
    script.push_back(reg_row(CFG_DATA_START, 32'hFFFF_FFFF));
    script.push_back(check_row(CMD_OPEN, 12'd3, 32'd127, 1'b0, 12'd3));   // wraps
    script.push_back(drive_row(CMD_ADVANCE, 13'd0, 8'd0, 12'd0));

    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    foreach (script[i]) begin
      if (script[i].is_reg) begin
        settle();
        write_reg(script[i].sel, script[i].val);
      end else begin
        send_word(script[i].w, script[i].typed, script[i].want);
      end
    end

    // Register settings, extremes included; small clusters carry most words.
    run_phase(8'd1,   $urandom(),     60);
    run_phase(8'd0,   32'hFFFF_FFFF,  60);
    run_phase(8'd2,   $urandom(),     70);
    run_phase(8'd3,   32'd0,          70);
    run_phase(8'd255, $urandom(),     90);
    run_phase(8'd128, 32'hFFFF_FFF0,  90);
    run_phase(8'd4,   $urandom(),     70);
    run_phase(8'($urandom_range(1, 8)), $urandom(), 40);

    settle();
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
